FILE: hdl/lma_pkg.sv
// Shared types and constants for the LED matrix animator.
package lma_pkg;

  // Default number of glyphs the message store is sized for.
  localparam int MSG_GLYPHS_DEF = 8;
  // Rows of the message store reachable through the six-bit address.
  localparam int MAX_STORE_ROWS = 8;
  // Glyph count width: holds counts up to 63.
  localparam int CNT_W = 6;

  localparam logic [4:0] SLOW_LIMIT     = 5'd30;
  localparam logic [4:0] PUSH_LIMIT_PAL = 5'd7;
  localparam logic [4:0] PUSH_LIMIT_STD = 5'd8;
  localparam logic [7:0] ROW_OFF        = 8'hFF;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_PAL    = 2'd1;
  localparam logic [1:0] CFG_TILES  = 2'd2;

  localparam logic [1:0] MODE_RESET  = 2'd2;
  localparam logic [3:0] TILES_RESET = 4'd4;

  typedef enum logic [1:0] {
    MODE_ROTATE  = 2'd0,
    MODE_PUSH    = 2'd1,
    MODE_MARQUEE = 2'd2,
    MODE_IDLE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ROW  = 2'd1,
    CMD_MSG  = 2'd2
  } cmd_t;

  typedef logic [7:0][7:0] frame_t;

  // Byte write into the message store.
  typedef struct packed {
    logic       en;
    logic [2:0] row;
    logic [2:0] lane;
    logic [7:0] data;
  } msg_wr_t;

  // One result word.
  typedef struct packed {
    frame_t rows;
    logic   advanced;
  } result_t;

endpackage

FILE: hdl/lma_msg_store.sv
// Message store: one glyph row per entry, byte writes, registered row read.
module lma_msg_store #(
  parameter int  MSG_GLYPHS = lma_pkg::MSG_GLYPHS_DEF,
  localparam int GI_W       = (MSG_GLYPHS > 1) ? $clog2(MSG_GLYPHS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lma_pkg::msg_wr_t               wr,
  input  logic [GI_W-1:0]                rd_row,
  output lma_pkg::frame_t                rd_bytes
);

  localparam int STORE_ROWS = (MSG_GLYPHS < lma_pkg::MAX_STORE_ROWS) ?
                              MSG_GLYPHS : lma_pkg::MAX_STORE_ROWS;
  localparam int ROW_W      = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;

  logic [63:0]             mem_r [STORE_ROWS];
  logic [STORE_ROWS*8-1:0] valid_r;
  logic [63:0]             rd_data_r;
  logic [7:0]              rd_vld_r;
  logic [7:0]              fwd_mask_r;
  logic [7:0]              fwd_data_r;

  logic [ROW_W-1:0] rd_idx;
  logic [ROW_W-1:0] wr_idx;
  logic             rd_ok;
  logic             wr_hit;
  logic [7:0]       hit_mask;

  assign rd_idx   = rd_row[ROW_W-1:0];
  assign wr_idx   = wr.row[ROW_W-1:0];
  assign rd_ok    = (32'(rd_row) < 32'(STORE_ROWS));
  assign wr_hit   = wr.en && rd_ok && (wr_idx == rd_idx);
  assign hit_mask = wr_hit ? (8'h01 << wr.lane) : 8'h00;

  // Write-first: a byte written in the same cycle is forwarded to the read word.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr_idx][{wr.lane, 3'b000} +: 8] <= wr.data;
    end
    if (rd_ok) begin
      rd_data_r <= mem_r[rd_idx];
    end
    fwd_data_r <= wr.data;
  end

  // Unwritten bytes read as all off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_vld_r   <= '0;
      fwd_mask_r <= '0;
    end else begin
      if (wr.en) begin
        valid_r[{wr_idx, wr.lane}] <= 1'b1;
      end
      rd_vld_r   <= rd_ok ? (valid_r[{rd_idx, 3'b000} +: 8] | hit_mask) : 8'h00;
      fwd_mask_r <= hit_mask;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (fwd_mask_r[i]) begin
        rd_bytes[i] = fwd_data_r;
      end else begin
        rd_bytes[i] = rd_vld_r[i] ? rd_data_r[i*8 +: 8] : lma_pkg::ROW_OFF;
      end
    end
  end

endmodule

FILE: hdl/lma_engine.sv
// Frame, tick counter and marquee position; applies one accepted word per cycle.
module lma_engine #(
  parameter int  MSG_GLYPHS = lma_pkg::MSG_GLYPHS_DEF,
  localparam int GI_W       = (MSG_GLYPHS > 1) ? $clog2(MSG_GLYPHS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [1:0]           cmd,
  input  logic [5:0]           address,
  input  logic [7:0]           value,
  input  lma_pkg::mode_t       mode,
  input  logic                 pal_system,
  input  logic [3:0]           marquee_tiles,
  input  lma_pkg::frame_t      msg_bytes,
  output logic [GI_W-1:0]      rd_row,
  output lma_pkg::msg_wr_t     wr,
  output lma_pkg::result_t     result
);

  localparam int STORE_ROWS  = (MSG_GLYPHS < lma_pkg::MAX_STORE_ROWS) ?
                               MSG_GLYPHS : lma_pkg::MAX_STORE_ROWS;
  localparam int STORE_BYTES = STORE_ROWS * 8;
  localparam logic [lma_pkg::CNT_W-1:0] GLYPH_CAP = lma_pkg::CNT_W'(MSG_GLYPHS);

  lma_pkg::frame_t frame_r, frame_nxt;
  logic [4:0]      tick_r, tick_nxt;
  logic [2:0]      col_r, col_nxt;
  logic [GI_W-1:0] gi_r, gi_nxt;

  logic [4:0]               tick_inc;
  logic [4:0]               limit;
  logic [lma_pkg::CNT_W-1:0] glyphs;
  logic [lma_pkg::CNT_W-1:0] gi_inc;
  logic                     adv;

  assign tick_inc = tick_r + 5'd1;
  assign gi_inc   = lma_pkg::CNT_W'(gi_r) + lma_pkg::CNT_W'(1);

  always_comb begin
    if (mode == lma_pkg::MODE_PUSH) begin
      limit = pal_system ? lma_pkg::PUSH_LIMIT_PAL : lma_pkg::PUSH_LIMIT_STD;
    end else begin
      limit = lma_pkg::SLOW_LIMIT;
    end
  end

  // Glyph count clamped to one..MSG_GLYPHS.
  always_comb begin
    if (marquee_tiles == 4'd0) begin
      glyphs = lma_pkg::CNT_W'(1);
    end else if (lma_pkg::CNT_W'(marquee_tiles) > GLYPH_CAP) begin
      glyphs = GLYPH_CAP;
    end else begin
      glyphs = lma_pkg::CNT_W'(marquee_tiles);
    end
  end

  always_comb begin
    frame_nxt = frame_r;
    tick_nxt  = tick_r;
    col_nxt   = col_r;
    gi_nxt    = gi_r;
    adv       = 1'b0;
    wr        = '0;
    if (in_fire) begin
      case (lma_pkg::cmd_t'(cmd))
        lma_pkg::CMD_TICK: begin
          if (mode != lma_pkg::MODE_IDLE) begin
            if (tick_inc > limit) begin
              tick_nxt = 5'd0;
              adv      = 1'b1;
              case (mode)
                lma_pkg::MODE_ROTATE: begin
                  for (int i = 0; i < 8; i++) begin
                    frame_nxt[i] = {frame_r[i][0], frame_r[i][7:1]};
                  end
                end
                lma_pkg::MODE_PUSH: begin
                  for (int i = 1; i < 8; i++) begin
                    frame_nxt[i] = frame_r[i-1];
                  end
                  frame_nxt[0] = lma_pkg::ROW_OFF;
                end
                default: begin
                  for (int i = 0; i < 8; i++) begin
                    frame_nxt[i] = {msg_bytes[i][3'd7 - col_r], frame_r[i][7:1]};
                  end
                  if (col_r == 3'd7) begin
                    col_nxt = 3'd0;
                    gi_nxt  = (gi_inc >= glyphs) ? '0 : gi_inc[GI_W-1:0];
                  end else begin
                    col_nxt = col_r + 3'd1;
                  end
                end
              endcase
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
        lma_pkg::CMD_ROW: begin
          if (address[5:3] == 3'd0) begin
            frame_nxt[address[2:0]] = value;
          end
        end
        lma_pkg::CMD_MSG: begin
          if (7'(address) < 7'(STORE_BYTES)) begin
            wr.en   = 1'b1;
            wr.row  = address[5:3];
            wr.lane = address[2:0];
            wr.data = value;
          end
        end
        default: ;
      endcase
    end
  end

  // The store is read ahead at the glyph the next word will see.
  assign rd_row          = gi_nxt;
  assign result.rows     = frame_nxt;
  assign result.advanced = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= {8{lma_pkg::ROW_OFF}};
      tick_r  <= 5'd0;
      col_r   <= 3'd0;
      gi_r    <= '0;
    end else begin
      frame_r <= frame_nxt;
      tick_r  <= tick_nxt;
      col_r   <= col_nxt;
      gi_r    <= gi_nxt;
    end
  end

endmodule

FILE: hdl/lma_out_skid.sv
// Output register plus a skid stage; in_ready drops only while the skid is full.
module lma_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  lma_pkg::result_t  in_word,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lma_pkg::result_t  out_word
);

  logic             out_valid_r;
  logic             skid_valid_r;
  lma_pkg::result_t out_word_r;
  lma_pkg::result_t skid_word_r;
  logic             out_fire;

  assign out_fire  = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_word_r <= skid_word_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_word_r <= in_word;
      end else begin
        out_word_r <= in_word;
      end
    end
  end

endmodule

FILE: hdl/led_matrix_animator.sv
// Top level of the 8x8 LED matrix animator.
// Input channel (in_valid/in_ready): one word per command - a tick, a direct
//   row write or a message byte load. Result channel (out_valid/out_ready):
//   one word per input word carrying all eight rows and the advanced flag.
// Result path: the result word is registered in the output register.
// Throughput: one word per cycle while in_ready is high; frame and counters
//   update with each word and the message store row is read ahead at the glyph
//   the next tick needs, same-cycle byte writes forwarded into the read word.
// Receiver stall: the output register plus one skid word absorb a stall;
//   in_ready drops only once both are full and returns the cycle after the
//   receiver takes a word.
// Reset (rst_n low, synchronous): frame rows all off (0xFF), tick counter,
//   glyph column and glyph index cleared, every message byte reads as 0xFF
//   (per-byte valid flags), mode marquee, NTSC timing, four glyphs. Ready
//   right after reset; no clearing pass.
// Config port: cfg_we writes cfg_wdata into register cfg_index at once (0 mode,
//   1 pal_system, 2 marquee_tiles); the user writes only while idle, unchecked.
module led_matrix_animator #(
  parameter int MSG_GLYPHS = lma_pkg::MSG_GLYPHS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [5:0] in_address,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_row_0,
  output logic [7:0] out_row_1,
  output logic [7:0] out_row_2,
  output logic [7:0] out_row_3,
  output logic [7:0] out_row_4,
  output logic [7:0] out_row_5,
  output logic [7:0] out_row_6,
  output logic [7:0] out_row_7,
  output logic       out_advanced,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_wdata
);

  localparam int GI_W = (MSG_GLYPHS > 1) ? $clog2(MSG_GLYPHS) : 1;

  // Configuration registers
  logic [1:0] mode_r;
  logic       pal_r;
  logic [3:0] tiles_r;

  logic              in_fire;
  logic [GI_W-1:0]   rd_row;
  lma_pkg::msg_wr_t  msg_wr;
  lma_pkg::frame_t   msg_bytes;
  lma_pkg::result_t  result;
  lma_pkg::result_t  out_word;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lma_pkg::MODE_RESET;
      pal_r   <= 1'b0;
      tiles_r <= lma_pkg::TILES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lma_pkg::CFG_MODE:  mode_r  <= cfg_wdata[1:0];
        lma_pkg::CFG_PAL:   pal_r   <= cfg_wdata[0];
        lma_pkg::CFG_TILES: tiles_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lma_engine #(
    .MSG_GLYPHS (MSG_GLYPHS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .cmd           (in_cmd),
    .address       (in_address),
    .value         (in_value),
    .mode          (lma_pkg::mode_t'(mode_r)),
    .pal_system    (pal_r),
    .marquee_tiles (tiles_r),
    .msg_bytes     (msg_bytes),
    .rd_row        (rd_row),
    .wr            (msg_wr),
    .result        (result)
  );

  // Message store: read word always holds the row of the current glyph.
  lma_msg_store #(
    .MSG_GLYPHS (MSG_GLYPHS)
  ) u_msg_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (msg_wr),
    .rd_row   (rd_row),
    .rd_bytes (msg_bytes)
  );

  lma_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_word   (result),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_row_0    = out_word.rows[0];
  assign out_row_1    = out_word.rows[1];
  assign out_row_2    = out_word.rows[2];
  assign out_row_3    = out_word.rows[3];
  assign out_row_4    = out_word.rows[4];
  assign out_row_5    = out_word.rows[5];
  assign out_row_6    = out_word.rows[6];
  assign out_row_7    = out_word.rows[7];
  assign out_advanced = out_word.advanced;

endmodule
